[hw/rtl/ptt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the tick/tock timer
// Request and result word layouts and the request codes.
// ----------------------------------------------------------------------------
package ptt_pkg;

    // Request codes
    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_RAISE      = 3'd1;
    localparam logic [2:0] REQ_LOWER      = 3'd2;
    localparam logic [2:0] REQ_CLEAR      = 3'd3;
    localparam logic [2:0] REQ_SET_PHASE  = 3'd4;
    localparam logic [2:0] REQ_STOP       = 3'd5;
    localparam logic [2:0] REQ_RESUME     = 3'd6;

    // Packet interval after reset, in microseconds
    localparam logic [15:0] INTERVAL_RESET = 16'd20000;

    // Frequency offset limits
    localparam logic signed [15:0] OFFSET_MAX = 16'sh7FFF;
    localparam logic signed [15:0] OFFSET_MIN = 16'sh8000;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] phase_value;
    } ptt_req_t;

    typedef struct packed {
        logic               tick_event;
        logic               tock_event;
        logic               is_running;
        logic signed [15:0] offset_now;
        logic signed [15:0] phase_now;
    } ptt_rsp_t;

endpackage
`default_nettype wire

[hw/rtl/ptt_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_core: timer state and single-pass update
// Holds counter, reloads, offset and phase; applies one request word per step
// and presents the result word of that step combinationally.
// ----------------------------------------------------------------------------
module ptt_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire ptt_pkg::ptt_req_t req,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_data,
    output ptt_pkg::ptt_rsp_t      rsp
);
    import ptt_pkg::*;

    localparam int CW = COUNT_WIDTH;
    // Signed width wide enough for every reload sum and the counter range
    localparam int SW = (CW + 2 > 19) ? CW + 2 : 19;
    localparam logic [SW-1:0] CMAX = {{(SW-CW){1'b0}}, {CW{1'b1}}};
    localparam longint RR_RAW = longint'(INTERVAL_RESET) / 2 - 1;
    localparam longint CMAX_L = (longint'(1) <<< CW) - 1;
    localparam logic [CW-1:0] RELOAD_RESET =
        (RR_RAW > CMAX_L) ? {CW{1'b1}} : CW'(RR_RAW);

    // Clamp a signed sum into 0 .. 2^CW-1
    function automatic logic [CW-1:0] sat_reload(input logic signed [SW-1:0] v);
        logic [CW-1:0] r;
        if (v[SW-1]) begin
            r = '0;
        end else if (v > $signed(CMAX)) begin
            r = {CW{1'b1}};
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    logic [15:0]         interval_reg;
    logic [CW-1:0]       count_reg,   count_next;
    logic [CW-1:0]       active_reg,  active_next;
    logic [CW-1:0]       pending_reg, pending_next;
    logic                tick_next_reg, tick_next_next;
    logic                running_reg, running_next;
    logic signed [15:0]  offset_reg,  offset_next;
    logic signed [15:0]  phase_reg,   phase_next;

    logic [15:0]         half;
    logic [15:0]         cfg_half;
    logic signed [SW-1:0] half_ext;
    logic signed [SW-1:0] off_ext;
    logic signed [SW-1:0] phase_ext;
    logic signed [SW-1:0] tick_sum;
    logic signed [SW-1:0] tock_sum;
    logic signed [SW-1:0] cfg_sum;
    logic signed [16:0]  pv_ext;
    logic signed [16:0]  lim_pos;
    logic signed [16:0]  lim_neg;
    logic signed [15:0]  phase_clamped;
    logic                ev_tick;
    logic                ev_tock;

    // Reload candidates for the next tick and tock
    assign half      = {1'b0, interval_reg[15:1]};
    assign cfg_half  = {1'b0, cfg_data[15:1]};
    assign half_ext  = $signed({{(SW-16){1'b0}}, half});
    assign off_ext   = $signed({{(SW-16){offset_reg[15]}}, offset_reg});
    assign phase_ext = $signed({{(SW-16){phase_reg[15]}}, phase_reg});
    assign tick_sum  = half_ext + off_ext - SW'(1);
    assign tock_sum  = half_ext + phase_ext + off_ext - SW'(1);
    assign cfg_sum   = $signed({{(SW-16){1'b0}}, cfg_half}) - SW'(1);

    // Clamp the requested phase to plus or minus half the interval
    assign pv_ext  = {req.phase_value[15], req.phase_value};
    assign lim_pos = $signed({1'b0, half});
    assign lim_neg = -lim_pos;
    always_comb
    begin
        if (pv_ext > lim_pos) begin
            phase_clamped = lim_pos[15:0];
        end else if (pv_ext < lim_neg) begin
            phase_clamped = lim_neg[15:0];
        end else begin
            phase_clamped = req.phase_value;
        end
    end

    // Apply one request word
    always_comb
    begin
        count_next     = count_reg;
        active_next    = active_reg;
        pending_next   = pending_reg;
        tick_next_next = tick_next_reg;
        running_next   = running_reg;
        offset_next    = offset_reg;
        phase_next     = phase_reg;
        ev_tick        = 1'b0;
        ev_tock        = 1'b0;
        case (req.req_type)
            REQ_TICK:
            begin
                if (running_reg) begin
                    if (count_reg >= active_reg) begin
                        count_next  = '0;
                        active_next = pending_reg;
                        if (tick_next_reg) begin
                            pending_next   = sat_reload(tick_sum);
                            tick_next_next = 1'b0;
                            ev_tick        = 1'b1;
                        end else begin
                            pending_next   = sat_reload(tock_sum);
                            phase_next     = '0;
                            tick_next_next = 1'b1;
                            ev_tock        = 1'b1;
                        end
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            REQ_RAISE:
            begin
                if (offset_reg != OFFSET_MAX) begin
                    offset_next = offset_reg + 16'sd1;
                end
            end
            REQ_LOWER:
            begin
                if (offset_reg != OFFSET_MIN) begin
                    offset_next = offset_reg - 16'sd1;
                end
            end
            REQ_CLEAR:
            begin
                offset_next = '0;
            end
            REQ_SET_PHASE:
            begin
                phase_next = phase_clamped;
            end
            REQ_STOP:
            begin
                count_next   = '0;
                running_next = 1'b0;
            end
            REQ_RESUME:
            begin
                // Restart on a tock: active takes the plain half interval
                active_next    = sat_reload(half_ext);
                pending_next   = sat_reload(tock_sum);
                phase_next     = '0;
                tick_next_next = 1'b1;
                count_next     = '0;
                running_next   = 1'b1;
                ev_tock        = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Result word of this step, taken after the update
    always_comb
    begin
        rsp.tick_event = ev_tick;
        rsp.tock_event = ev_tock;
        rsp.is_running = running_next;
        rsp.offset_now = offset_next;
        rsp.phase_now  = phase_next;
    end

    // Hold state; advance on a step, take the interval on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            interval_reg  <= INTERVAL_RESET;
            count_reg     <= '0;
            active_reg    <= RELOAD_RESET;
            pending_reg   <= RELOAD_RESET;
            tick_next_reg <= 1'b0;
            running_reg   <= 1'b0;
            offset_reg    <= '0;
            phase_reg     <= '0;
        end else if (cfg_we) begin
            interval_reg <= cfg_data;
            pending_reg  <= sat_reload(cfg_sum);
        end else if (step) begin
            count_reg     <= count_next;
            active_reg    <= active_next;
            pending_reg   <= pending_next;
            tick_next_reg <= tick_next_next;
            running_reg   <= running_next;
            offset_reg    <= offset_next;
            phase_reg     <= phase_next;
        end
    end

`ifndef SYNTH
    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg_we && req.req_type == REQ_STOP |=> !running_reg && count_reg == '0)
        else $error("stop did not halt the counter");
    a_resume_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg_we && req.req_type == REQ_RESUME
        |=> running_reg && tick_next_reg && count_reg == '0 && phase_reg == '0)
        else $error("resume did not restart on a tock");
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp.tick_event && rsp.tock_event))
        else $error("tick and tock fired together");
    a_tock_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg_we && rsp.tock_event |=> phase_reg == '0 && tick_next_reg)
        else $error("tock left a phase shift pending");
    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cfg_we && !running_reg && req.req_type == REQ_TICK |=> $stable(count_reg))
        else $error("counter moved while stopped");
`endif

endmodule
`default_nettype wire

[hw/rtl/phase_locked_tick_tock_timer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted request word waits in the input register, and its result
//   word is then captured in the result register; rsp_stall can hold it there.
// Throughput: one word per cycle unless stalled (ptt_core single-pass update).
// Reset: rst_n clears all control state at once; interval 20000 us, timer
//   stopped, next event a tock, offset and phase zero. No clearing pass.
// ----------------------------------------------------------------------------
// phase_locked_tick_tock_timer: microsecond tick/tock packet timer
// Input register, single-pass timer update, registered result word.
// ----------------------------------------------------------------------------
module phase_locked_tick_tock_timer #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire ptt_pkg::ptt_req_t req_word,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output ptt_pkg::ptt_rsp_t      rsp_word,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [15:0]       cfg_data
);
    import ptt_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    ptt_req_t  s1_word_reg;
    logic      rsp_valid_reg, rsp_valid_next;
    ptt_rsp_t  rsp_word_reg;
    ptt_rsp_t  core_rsp;
    logic      advance;
    logic      step;
    logic      accept;

    // Move the held word on when the result register is free or drained
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign step      = s1_valid_reg && advance;
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign s1_valid_next  = accept ? 1'b1 : (step ? 1'b0 : s1_valid_reg);
    assign rsp_valid_next = step ? 1'b1 : (rsp_valid_reg && rsp_stall);

    ptt_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .req      (s1_word_reg),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .rsp      (core_rsp)
    );

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture the request word and the result word
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_word_reg <= req_word;
        end
        if (step) begin
            rsp_word_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule
`default_nettype wire
